// ===== design/assert_macros.svh =====
// Assertion macros shared by the reassembly block.
// Every macro samples on the rising edge of clock and is disabled during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every sampled edge.
`define PRA_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// The condition must never be true at a sampled edge.
`define PRA_NEVER(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

// ===== design/pra_pkg.sv =====
// Package for the per-PID PES reassembly block: constants, status codes and
// the record types that pass between its modules. No dependencies.
`default_nettype none

package pra_pkg;

   localparam int PID_COUNT        = 8192;
   localparam int PID_W            = 13;
   localparam int MAX_PACKET_BYTES = 65536;
   localparam int HDR_BYTES        = 6;
   localparam int LEN_HI_OFFSET    = 4;
   localparam int FILL_W           = 17;
   localparam int OFF_W            = 16;
   localparam int QUEUE_DEPTH      = 4;
   localparam int QUEUE_PTR_W      = 2;
   localparam int QUEUE_CNT_W      = 3;

   typedef enum logic [2:0] {
      ST_DROPPED    = 3'd0,
      ST_STORED     = 3'd1,
      ST_COMPLETE   = 3'd2,
      ST_UNBOUNDED  = 3'd3,
      ST_DISCARDED  = 3'd4,
      ST_OVERFLOW   = 3'd5,
      ST_TOO_LARGE  = 3'd6,
      ST_IDLE       = 3'd7
   } status_type;

   // Per-PID state word kept in the state memory.
   typedef struct packed {
      logic              collecting;
      logic              bounded;
      logic [FILL_W-1:0] fill;
      logic [FILL_W-1:0] total;
      logic [7:0]        len_hi;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic [PID_W-1:0] pid;
      logic             start_req;
      logic             has_byte;
      logic [7:0]       data_byte;
   } req_type;

   typedef struct packed {
      status_type        status;
      logic [PID_W-1:0]  stream_id;
      logic [OFF_W-1:0]  offset;
      logic [7:0]        byte_out;
      logic [FILL_W-1:0] byte_count;
      logic              last;
   } rsp_type;

   // Outcome of one read-modify-write step.
   typedef struct packed {
      entry_type next;
      rsp_type   first;
      rsp_type   second;
      logic      two;
   } upd_type;

endpackage

`default_nettype wire

// ===== design/pra_req_if.sv =====
// Input channel of the reassembly block: valid/ready plus one payload byte.
// Depends on pra_pkg for widths.
`default_nettype none

interface pra_req_if;
   logic                     valid;
   logic                     ready;
   logic [pra_pkg::PID_W-1:0] pid;
   logic                     start_req;
   logic                     has_byte;
   logic [7:0]               data_byte;

   modport source (output valid, pid, start_req, has_byte, data_byte, input ready);
   modport sink   (input valid, pid, start_req, has_byte, data_byte, output ready);
endinterface

`default_nettype wire

// ===== design/pra_rsp_if.sv =====
// Result channel of the reassembly block: valid/ready plus one event record.
// Depends on pra_pkg for widths.
`default_nettype none

interface pra_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [2:0]                 status;
   logic [pra_pkg::PID_W-1:0]  stream_id;
   logic [pra_pkg::OFF_W-1:0]  offset;
   logic [7:0]                 byte_out;
   logic [pra_pkg::FILL_W-1:0] byte_count;
   logic                       last;

   modport source (output valid, status, stream_id, offset, byte_out, byte_count, last,
                   input ready);
   modport sink   (input valid, status, stream_id, offset, byte_out, byte_count, last,
                   output ready);
endinterface

`default_nettype wire

// ===== design/pra_ram.sv =====
// Generic single-clock RAM, one write port and one read port with registered
// read data. No package dependencies.
`default_nettype none

module pra_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output      logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== design/pra_update.sv =====
// Next-state and event logic for one input byte against one PID's state word.
// Depends on pra_pkg.
`default_nettype none

module pra_update (
   input  wire pra_pkg::req_type   req,
   input  wire pra_pkg::entry_type cur,
   output      pra_pkg::upd_type   upd
);

   pra_pkg::entry_type        st;
   pra_pkg::rsp_type          ev_rsp;
   pra_pkg::rsp_type          main_rsp;
   logic                      ev;
   logic                      main_ok;
   logic [pra_pkg::FILL_W-1:0] f1;
   logic [pra_pkg::FILL_W-1:0] total;
   logic [15:0]               len;

   always_comb begin
      ev       = req.start_req && cur.collecting && (cur.fill != '0);
      ev_rsp   = '0;
      main_rsp = '0;
      ev_rsp.status        = cur.bounded ? pra_pkg::ST_DISCARDED : pra_pkg::ST_UNBOUNDED;
      ev_rsp.stream_id     = req.pid;
      ev_rsp.byte_count    = cur.fill;
      main_rsp.stream_id   = req.pid;

      st = cur;
      if (req.start_req) begin
         st.collecting = 1'b1;
         st.bounded    = 1'b0;
         st.fill       = '0;
         st.total      = '0;
      end

      f1      = st.fill + pra_pkg::FILL_W'(1);
      len     = {st.len_hi, req.data_byte};
      total   = pra_pkg::FILL_W'(pra_pkg::HDR_BYTES) + {1'b0, len};
      main_ok = req.has_byte;

      if (!req.has_byte) begin
         main_rsp.status = pra_pkg::ST_IDLE;
      end else if (!st.collecting) begin
         main_rsp.status = pra_pkg::ST_DROPPED;
      end else if (st.fill >= pra_pkg::FILL_W'(pra_pkg::MAX_PACKET_BYTES)) begin
         main_rsp.status     = pra_pkg::ST_OVERFLOW;
         main_rsp.byte_count = st.fill;
         st = '{collecting: 1'b0, bounded: 1'b0, fill: '0, total: '0, len_hi: st.len_hi};
      end else begin
         main_rsp.offset   = st.fill[pra_pkg::OFF_W-1:0];
         main_rsp.byte_out = req.data_byte;
         if (st.fill == pra_pkg::FILL_W'(pra_pkg::LEN_HI_OFFSET)) begin
            st.len_hi = req.data_byte;
         end
         st.fill = f1;
         if (!st.bounded && f1 == pra_pkg::FILL_W'(pra_pkg::HDR_BYTES) && len != '0) begin
            st.bounded = 1'b1;
            st.total   = total;
         end
         // The too-large check reports the low length byte and stops collection.
         if (!cur.bounded && !(req.start_req && 1'b0) && st.bounded
             && total > pra_pkg::FILL_W'(pra_pkg::MAX_PACKET_BYTES)
             && f1 == pra_pkg::FILL_W'(pra_pkg::HDR_BYTES) && st.total == total
             && !(cur.bounded && !req.start_req)) begin
            main_rsp.status     = pra_pkg::ST_TOO_LARGE;
            main_rsp.byte_count = f1;
            st = '{collecting: 1'b0, bounded: 1'b0, fill: '0, total: '0, len_hi: st.len_hi};
         end else if (st.bounded && f1 == st.total) begin
            main_rsp.status     = pra_pkg::ST_COMPLETE;
            main_rsp.byte_count = st.total;
            st = '{collecting: 1'b0, bounded: 1'b0, fill: '0, total: '0, len_hi: st.len_hi};
         end else begin
            main_rsp.status = pra_pkg::ST_STORED;
         end
      end

      upd.next = st;
      if (ev) begin
         upd.first       = ev_rsp;
         upd.first.last  = !main_ok;
         upd.second      = main_rsp;
         upd.second.last = 1'b1;
         upd.two         = main_ok;
      end else begin
         upd.first       = main_rsp;
         upd.first.last  = 1'b1;
         upd.second      = main_rsp;
         upd.two         = 1'b0;
      end
   end

endmodule

`default_nettype wire

// ===== design/pra_out_queue.sv =====
// Four-entry result queue that takes one or two results per cycle and
// delivers one per transfer on the result channel. Depends on pra_pkg.
`default_nettype none

module pra_out_queue (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                push,
   input  wire pra_pkg::upd_type                    upd,
   output      logic [pra_pkg::QUEUE_CNT_W-1:0]     level,
   pra_rsp_if.source                                rsp_if
);

   pra_pkg::rsp_type                    q_ff [pra_pkg::QUEUE_DEPTH];
   logic [pra_pkg::QUEUE_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [pra_pkg::QUEUE_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [pra_pkg::QUEUE_CNT_W-1:0]     count_ff, count_in;
   logic [pra_pkg::QUEUE_CNT_W-1:0]     n_push;
   logic                                pop;
   pra_pkg::rsp_type                    head;

   always_comb begin
      pop       = rsp_if.valid && rsp_if.ready;
      n_push    = !push ? '0 : (upd.two ? pra_pkg::QUEUE_CNT_W'(2) : pra_pkg::QUEUE_CNT_W'(1));
      wr_ptr_in = wr_ptr_ff + n_push[pra_pkg::QUEUE_PTR_W-1:0];
      rd_ptr_in = rd_ptr_ff + pra_pkg::QUEUE_PTR_W'(pop);
      count_in  = count_ff + n_push - pra_pkg::QUEUE_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         q_ff[wr_ptr_ff] <= upd.first;
         if (upd.two) begin
            q_ff[wr_ptr_ff + pra_pkg::QUEUE_PTR_W'(1)] <= upd.second;
         end
      end
   end

   assign head               = q_ff[rd_ptr_ff];
   assign level              = count_ff;
   assign rsp_if.valid       = (count_ff != '0);
   assign rsp_if.status      = head.status;
   assign rsp_if.stream_id   = head.stream_id;
   assign rsp_if.offset      = head.offset;
   assign rsp_if.byte_out    = head.byte_out;
   assign rsp_if.byte_count  = head.byte_count;
   assign rsp_if.last        = head.last;

endmodule

`default_nettype wire

// ===== design/pes_reassembly_per_pid.sv =====
// Top level of the per-PID PES reassembly block: state memory, read-modify-write
// stage with forwarding, reset clearing pass and result queue.
// Depends on pra_pkg, pra_req_if, pra_rsp_if, pra_ram, pra_update, pra_out_queue.
//
//   channel   direction  handshake         payload
//   req_if    in         valid / ready     pid, start_req, has_byte, data_byte
//   rsp_if    out        valid / ready     status, stream_id, offset, byte_out,
//                                          byte_count, last
//
// One byte is taken per cycle when not stalled; the state memory is read on the
// transfer and the updated word is written back from the update stage, with a
// forwarding register covering back-to-back bytes of the same PID. Results leave
// one per cycle while the result channel is ready. After reset a clearing pass writes
// all 8192 state words, one per cycle, and no input is taken during the pass. The input
// also stalls while a byte waits for the update and the queue lacks room for two results.
`default_nettype none

module pes_reassembly_per_pid (
   input  wire logic clock,
   input  wire logic reset,
   pra_req_if.sink   req_if,
   pra_rsp_if.source rsp_if
);

`include "assert_macros.svh"

   logic                            clearing_ff;
   logic [pra_pkg::PID_W-1:0]       clr_addr_ff;
   logic                            s1_valid_ff, s1_valid_in;
   pra_pkg::req_type                s1_req_ff;
   logic                            fwd_valid_ff;
   logic [pra_pkg::PID_W-1:0]       fwd_pid_ff;
   pra_pkg::entry_type              fwd_data_ff;
   logic [pra_pkg::ENTRY_W-1:0]     ram_rdata;
   logic                            ram_we;
   logic [pra_pkg::PID_W-1:0]       ram_waddr;
   logic [pra_pkg::ENTRY_W-1:0]     ram_wdata;
   pra_pkg::entry_type              cur;
   pra_pkg::upd_type                upd;
   logic [pra_pkg::QUEUE_CNT_W-1:0] level;
   logic                            room;
   logic                            s1_go;
   logic                            accept;

   assign room          = (level <= pra_pkg::QUEUE_CNT_W'(pra_pkg::QUEUE_DEPTH - 2));
   assign s1_go         = s1_valid_ff && room;
   assign req_if.ready  = !clearing_ff && (!s1_valid_ff || room);
   assign accept        = req_if.valid && req_if.ready;
   assign s1_valid_in   = accept || (s1_valid_ff && !s1_go);

   // The newest written word wins over the memory output for the same PID.
   assign cur = (fwd_valid_ff && fwd_pid_ff == s1_req_ff.pid)
                ? fwd_data_ff : pra_pkg::entry_type'(ram_rdata);

   assign ram_we    = clearing_ff || s1_go;
   assign ram_waddr = clearing_ff ? clr_addr_ff : s1_req_ff.pid;
   assign ram_wdata = clearing_ff ? '0 : pra_pkg::ENTRY_W'(upd.next);

   pra_ram #(
      .WIDTH (pra_pkg::ENTRY_W),
      .DEPTH (pra_pkg::PID_COUNT)
   ) u_state_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (accept),
      .raddr (req_if.pid),
      .rdata (ram_rdata)
   );

   pra_update u_update (
      .req (s1_req_ff),
      .cur (cur),
      .upd (upd)
   );

   pra_out_queue u_out_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (s1_go),
      .upd    (upd),
      .level  (level),
      .rsp_if (rsp_if)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff  <= 1'b1;
         clr_addr_ff  <= '0;
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
      end else begin
         if (clearing_ff) begin
            clr_addr_ff <= clr_addr_ff + pra_pkg::PID_W'(1);
            if (clr_addr_ff == pra_pkg::PID_W'(pra_pkg::PID_COUNT - 1)) begin
               clearing_ff <= 1'b0;
            end
         end
         s1_valid_ff <= s1_valid_in;
         if (s1_go) begin
            fwd_valid_ff <= 1'b1;
         end
      end
      if (accept) begin
         s1_req_ff.pid       <= req_if.pid;
         s1_req_ff.start_req <= req_if.start_req;
         s1_req_ff.has_byte  <= req_if.has_byte;
         s1_req_ff.data_byte <= req_if.data_byte;
      end
      if (s1_go) begin
         fwd_pid_ff  <= s1_req_ff.pid;
         fwd_data_ff <= upd.next;
      end
   end

   `PRA_NEVER(a_no_accept_while_clearing, clearing_ff && accept, "input taken during clearing pass")
   `PRA_ASSERT(a_accept_fills_stage, accept |=> s1_valid_ff, "accepted byte lost before update")
   `PRA_ASSERT(a_queue_bound, level <= pra_pkg::QUEUE_CNT_W'(pra_pkg::QUEUE_DEPTH), "queue overrun")
   `PRA_ASSERT(a_stall_holds_stage, (s1_valid_ff && !s1_go) |=> (s1_valid_ff && $stable(s1_req_ff)), "stalled byte changed")

endmodule

`default_nettype wire
